>>> hdl/irad_pkg.sv
// Package for the integer radical unit: default width, controller commands
// and datapath status. No dependencies.
`timescale 1ns / 1ps

package irad_pkg;

  localparam int VALUE_BITS_DEF = 31;

  typedef struct packed {
    logic load;
    logic div_start;
    logic div_step;
    logic mul_start;
    logic mul_sel_m;
    logic mul_step;
    logic update_m;
    logic next_d;
    logic capture;
  } irad_cmd_t;

  typedef struct packed {
    logic is_zero;
    logic div_last;
    logic mul_last;
    logic d_gt_q;
    logic rem_zero;
    logic m_gt_one;
  } irad_status_t;

endpackage

>>> hdl/integer_radical_unit.sv
// Channel     | Direction | Handshake          | Payload
// in          | input     | in_valid/in_stall   | in_n
// out         | output    | out_valid/out_stall | out_radical, out_bad_input
//
// One transaction at a time. Each trial division runs in the restoring divider and is
// repeated on the same divisor after every hit; each prime found adds a pass through
// the shift-add multiplier. The worst case is a prime n.
// Reset is synchronous, active low, and clears the controller, step counter and zero flag.
// A result waits in the output register while the next transaction is accepted.
// Top level of the integer radical unit; depends on irad_pkg, irad_ctrl, irad_dp.
`timescale 1ns / 1ps

module integer_radical_unit #(
  parameter int VALUE_BITS = irad_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [VALUE_BITS-1:0] in_n,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [VALUE_BITS-1:0] out_radical,
  output logic                  out_bad_input
);
  import irad_pkg::*;

  irad_cmd_t    cmd;
  irad_status_t status;

  irad_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  irad_dp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .in_n          (in_n),
    .out_radical   (out_radical),
    .out_bad_input (out_bad_input)
  );

endmodule

>>> hdl/irad_dp.sv
// Datapath for the integer radical unit: value, divisor and product registers,
// a restoring divider and a shift-add multiplier. Depends on irad_pkg.
`timescale 1ns / 1ps

module irad_dp #(
  parameter int VALUE_BITS = irad_pkg::VALUE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  irad_pkg::irad_cmd_t    cmd,
  output irad_pkg::irad_status_t status,
  input  logic [VALUE_BITS-1:0]  in_n,
  output logic [VALUE_BITS-1:0]  out_radical,
  output logic                   out_bad_input
);
  import irad_pkg::*;

  localparam int CNT_W = $clog2(VALUE_BITS);

  logic [VALUE_BITS-1:0] m_r, m_nxt;
  logic [VALUE_BITS-1:0] d_r, d_nxt;
  logic [VALUE_BITS-1:0] prod_r, prod_nxt;
  logic [VALUE_BITS-1:0] rem_r, rem_nxt;
  logic [VALUE_BITS-1:0] quo_r, quo_nxt;
  logic [VALUE_BITS-1:0] mcand_r, mcand_nxt;
  logic [VALUE_BITS-1:0] mplier_r, mplier_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  zero_r, zero_nxt;
  logic [VALUE_BITS-1:0] radical_r, radical_nxt;
  logic                  bad_r, bad_nxt;
  logic [VALUE_BITS:0]   trial;
  logic [VALUE_BITS:0]   diff;
  logic                  cnt_last;

  assign trial    = {rem_r, quo_r[VALUE_BITS-1]};
  assign diff     = trial - {1'b0, d_r};
  assign cnt_last = (cnt_r == CNT_W'(VALUE_BITS - 1));

  always_comb begin
    m_nxt       = m_r;
    d_nxt       = d_r;
    prod_nxt    = prod_r;
    rem_nxt     = rem_r;
    quo_nxt     = quo_r;
    mcand_nxt   = mcand_r;
    mplier_nxt  = mplier_r;
    cnt_nxt     = cnt_r;
    zero_nxt    = zero_r;
    radical_nxt = radical_r;
    bad_nxt     = bad_r;
    if (cmd.load) begin
      m_nxt    = in_n;
      d_nxt    = VALUE_BITS'(2);
      prod_nxt = VALUE_BITS'(1);
      zero_nxt = (in_n == '0);
    end
    if (cmd.div_start) begin
      rem_nxt = '0;
      quo_nxt = m_r;
      cnt_nxt = '0;
    end
    if (cmd.div_step) begin
      cnt_nxt = cnt_r + CNT_W'(1);
      if (trial >= {1'b0, d_r}) begin
        rem_nxt = diff[VALUE_BITS-1:0];
        quo_nxt = {quo_r[VALUE_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = trial[VALUE_BITS-1:0];
        quo_nxt = {quo_r[VALUE_BITS-2:0], 1'b0};
      end
    end
    if (cmd.update_m) begin
      m_nxt = quo_r;
    end
    if (cmd.next_d) begin
      d_nxt = (d_r == VALUE_BITS'(2)) ? VALUE_BITS'(3) : d_r + VALUE_BITS'(2);
    end
    if (cmd.mul_start) begin
      mcand_nxt  = prod_r;
      mplier_nxt = cmd.mul_sel_m ? m_r : d_r;
      prod_nxt   = '0;
      cnt_nxt    = '0;
    end
    if (cmd.mul_step) begin
      cnt_nxt    = cnt_r + CNT_W'(1);
      mcand_nxt  = {mcand_r[VALUE_BITS-2:0], 1'b0};
      mplier_nxt = {1'b0, mplier_r[VALUE_BITS-1:1]};
      if (mplier_r[0]) begin
        prod_nxt = prod_r + mcand_r;
      end
    end
    if (cmd.capture) begin
      radical_nxt = zero_r ? '0 : prod_r;
      bad_nxt     = zero_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      zero_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      zero_r <= zero_nxt;
    end
    m_r       <= m_nxt;
    d_r       <= d_nxt;
    prod_r    <= prod_nxt;
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
    mcand_r   <= mcand_nxt;
    mplier_r  <= mplier_nxt;
    radical_r <= radical_nxt;
    bad_r     <= bad_nxt;
  end

  always_comb begin
    status.is_zero  = zero_r;
    status.div_last = cnt_last;
    status.mul_last = cnt_last;
    status.d_gt_q   = (d_r > quo_r);
    status.rem_zero = (rem_r == '0);
    status.m_gt_one = (m_r > VALUE_BITS'(1));
  end

  assign out_radical   = radical_r;
  assign out_bad_input = bad_r;

endmodule

>>> hdl/irad_ctrl.sv
// Controller for the integer radical unit: sequences load, trial division,
// product updates and result hand-off. Depends on irad_pkg.
`timescale 1ns / 1ps

module irad_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  logic                   out_stall,
  input  irad_pkg::irad_status_t status,
  output irad_pkg::irad_cmd_t    cmd
);
  import irad_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_DECIDE,
    ST_MUL,
    ST_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   hit_r, hit_nxt;
  logic   fin_r, fin_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    hit_nxt       = hit_r;
    fin_nxt       = fin_r;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          hit_nxt   = 1'b0;
          fin_nxt   = 1'b0;
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        if (status.is_zero) begin
          state_nxt = ST_FINISH;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        priority if (status.rem_zero) begin
          cmd.update_m = 1'b1;
          if (!hit_r) begin
            cmd.mul_start = 1'b1;
            hit_nxt       = 1'b1;
            state_nxt     = ST_MUL;
          end else begin
            state_nxt = ST_START;
          end
        end else if (status.d_gt_q) begin
          if (status.m_gt_one) begin
            cmd.mul_start = 1'b1;
            cmd.mul_sel_m = 1'b1;
            fin_nxt       = 1'b1;
            state_nxt     = ST_MUL;
          end else begin
            state_nxt = ST_FINISH;
          end
        end else begin
          cmd.next_d = 1'b1;
          hit_nxt    = 1'b0;
          state_nxt  = ST_START;
        end
      end
      ST_MUL: begin
        cmd.mul_step = 1'b1;
        if (status.mul_last) begin
          state_nxt = fin_r ? ST_FINISH : ST_START;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          cmd.capture   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      hit_r       <= 1'b0;
      fin_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      hit_r       <= hit_nxt;
      fin_r       <= fin_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule
